// File: src/bole_pkg.sv
// bole_pkg: shared constants and types for the bounded ordered list engine
`timescale 1ns / 1ps

package bole_pkg;

  // list geometry
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // request field widths
  localparam int CMD_W = 3;
  localparam int POS_W = 16;
  localparam int VAL_W = 32;

  // remainder unit: position minus one is non-negative, so the sign bit drops
  localparam int DIV_W     = POS_W - 1;
  localparam int DIGIT_W   = 4;
  localparam int DIV_STEPS = (DIV_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIV_PAD_W = DIV_STEPS * DIGIT_W;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_FIRST = 3'd0,
    CMD_INSERT_AT    = 3'd1,
    CMD_REMOVE_FIRST = 3'd2,
    CMD_REMOVE_AT    = 3'd3,
    CMD_ERASE_VALUE  = 3'd4,
    CMD_EXISTS       = 3'd5,
    CMD_CLEAR        = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXEC
  } state_t;

  // remainder unit control
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             last;
    logic [CNT_W-1:0] rem;
  } mod_rsp_t;

endpackage

// File: src/bole_chan_if.sv
// bole_chan_if: valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps

interface bole_in_if import bole_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [POS_W-1:0] position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface bole_out_if import bole_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [CNT_W-1:0] count;
  logic             empty_res;

  modport source (output valid, ok, count, empty_res, input ready);
  modport sink   (input valid, ok, count, empty_res, output ready);
endinterface

// File: src/bounded_ordered_list_engine_core.sv
// bounded_ordered_list_engine_core: circular list held in a row of shifting cells
//
//   channel | dir | handshake     | payload
//   in_ch   | in  | valid / ready | command, position, value
//   out_ch  | out | valid / ready | ok, count, empty_res
//
// A request is taken in idle and its result is registered in the execute state, once
// the output register is free; insert_at and remove_at with a positive position on a
// non-empty list pass first through the divide state, where the remainder unit reduces
// the position minus one modulo the entry count. A new request is taken only in idle.
// The next request may be taken while a result waits; its update then holds until
// the output register frees up. Synchronous reset empties the list, cells keep data.
`timescale 1ns / 1ps

module bounded_ordered_list_engine_core import bole_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  bole_in_if.sink      in_ch,
  bole_out_if.source   out_ch
);

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r;
  logic [CNT_W-1:0]      out_count_r;
  logic                  out_empty_r;

  logic                  in_fire;
  logic                  need_div;
  logic [DIV_W-1:0]      pos_dec;
  logic                  slot_free;
  logic                  commit;
  mod_req_t              mod_req;
  mod_rsp_t              mod_rsp;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;
  cell_op_t              cell_op   [CAPACITY];

  logic                  any_match;
  logic [CNT_W-1:0]      first_idx;
  logic                  do_ins, do_rem, do_clear, res_ok;
  logic [CNT_W-1:0]      tgt;
  logic [CNT_W-1:0]      rem_inc;
  logic                  full, empty, neg, pos_zero;

  // request handshake
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pos_dec     = DIV_W'(in_ch.position - POS_W'(1));
  assign need_div    = ((cmd_t'(in_ch.command) == CMD_INSERT_AT) ||
                        (cmd_t'(in_ch.command) == CMD_REMOVE_AT)) &&
                       !in_ch.position[POS_W-1] && (in_ch.position != '0) &&
                       (count_r != '0);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd_t'(in_ch.command);
      pos_r <= in_ch.position;
      key_r <= DATA_WIDTH'(in_ch.value);
    end
  end

  // position modulo count
  assign mod_req.start    = in_fire && need_div;
  assign mod_req.dividend = pos_dec;
  assign mod_req.divisor  = count_r;

  bole_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // sequencer
  assign slot_free = !out_valid_r || out_ch.ready;
  assign commit    = (state_r == ST_EXEC) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = need_div ? ST_DIV : ST_EXEC;
        end
      end
      ST_DIV: begin
        if (mod_rsp.last) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // first live match, lowest slot wins
  always_comb begin
    any_match = 1'b0;
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i] && (CNT_W'(i) < count_r)) begin
        any_match = 1'b1;
        first_idx = CNT_W'(i);
      end
    end
  end

  // command decode
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign neg      = pos_r[POS_W-1];
  assign pos_zero = (pos_r == '0);
  assign rem_inc  = mod_rsp.rem + CNT_W'(1);

  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_clear = 1'b0;
    res_ok   = 1'b0;
    tgt      = '0;
    unique case (cmd_r)
      CMD_INSERT_FIRST: begin
        do_ins = !full;
      end
      CMD_INSERT_AT: begin
        if (pos_zero || empty) begin
          do_ins = !full;
        end else if (!neg) begin
          do_ins = !full;
          tgt    = rem_inc;
        end
      end
      CMD_REMOVE_FIRST: begin
        do_rem = !empty;
      end
      CMD_REMOVE_AT: begin
        if (!neg && !empty) begin
          do_rem = 1'b1;
          // wrap past the tail lands on the head
          if (!pos_zero && (rem_inc != count_r)) begin
            tgt = rem_inc;
          end
        end
      end
      CMD_ERASE_VALUE: begin
        do_rem = any_match;
        tgt    = first_idx;
      end
      CMD_EXISTS: begin
        res_ok = any_match;
      end
      CMD_CLEAR: begin
        do_clear = 1'b1;
      end
      default: ;
    endcase
    if (do_ins || do_rem || do_clear) begin
      res_ok = 1'b1;
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (commit) begin
      if (do_clear) begin
        count_nxt = '0;
      end else if (do_ins) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (do_rem) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // per-cell shift control
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = CELL_HOLD;
      if (commit && do_ins) begin
        if (CNT_W'(i) == tgt) begin
          cell_op[i] = CELL_LOAD;
        end else if (CNT_W'(i) > tgt) begin
          cell_op[i] = CELL_FROM_LEFT;
        end
      end else if (commit && do_rem && (CNT_W'(i) >= tgt)) begin
        cell_op[i] = CELL_FROM_RIGHT;
      end
    end
  end

  // row of cells, slot 0 is the head
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = key_r;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    bole_cell u_cell (
      .clk        (clk),
      .op         (cell_op[g]),
      .load_data  (key_r),
      .left_data  (left_w),
      .right_data (right_w),
      .key        (key_r),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_ok_r    <= res_ok;
      out_count_r <= count_nxt;
      out_empty_r <= (count_nxt == '0);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.ok        = out_ok_r;
  assign out_ch.count     = out_count_r;
  assign out_ch.empty_res = out_empty_r;

endmodule

// File: src/bole_cell.sv
// bole_cell: one list slot that loads, holds or takes a neighbor's word
`timescale 1ns / 1ps

module bole_cell import bole_pkg::*; (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [DATA_WIDTH-1:0] load_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] key,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  match
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;

  // slot update
  always_comb begin
    case (op)
      CELL_LOAD:       data_nxt = load_data;
      CELL_FROM_LEFT:  data_nxt = left_data;
      CELL_FROM_RIGHT: data_nxt = right_data;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // local compare for search
  assign data  = data_r;
  assign match = (data_r == key);

endmodule

// File: src/bole_mod_unit.sv
// bole_mod_unit: iterative remainder, one digit of the dividend per cycle
`timescale 1ns / 1ps

module bole_mod_unit import bole_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [DIV_PAD_W-1:0] dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     div_r, div_nxt;
  logic [CNT_W-1:0]     digit_rem;
  logic                 last_step;

  // restoring remainder over one digit
  always_comb begin
    logic [CNT_W:0]   trial;
    logic [CNT_W-1:0] acc;
    acc = rem_r;
    for (int b = 0; b < DIGIT_W; b++) begin
      trial = {acc, dvd_r[DIV_PAD_W-1-b]};
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      acc = trial[CNT_W-1:0];
    end
    digit_rem = acc;
  end

  assign last_step = busy_r && (step_r == STEP_W'(DIV_STEPS - 1));

  // sequencing
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = DIV_PAD_W'(req.dividend);
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = digit_rem;
      dvd_nxt  = dvd_r << DIGIT_W;
      step_nxt = step_r + STEP_W'(1);
      if (last_step) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign rsp.last = last_step;
  assign rsp.rem  = rem_r;

endmodule

// File: src/bole_checker.sv
// bole_checker: port-level checks on the list engine, bound to the top level
`timescale 1ns / 1ps

module bole_checker import bole_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_ok,
  input logic [CNT_W-1:0] out_count,
  input logic             out_empty_res
);

  // a result never reports more entries than the list can hold
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_W'(CAPACITY)))
    else $error("result count above capacity");

  // empty flag agrees with the reported count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == '0)))
    else $error("empty flag disagrees with count");

  // one request in work: intake closes right after a request is taken
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in work");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_ok) && $stable(out_count)))
    else $error("stalled result changed");

endmodule

bind bounded_ordered_list_engine_core bole_checker u_bole_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_ok        (out_ch.ok),
  .out_count     (out_ch.count),
  .out_empty_res (out_ch.empty_res)
);

// File: tb/bounded_ordered_list_engine_core_checker.sv
// bounded_ordered_list_engine_core_checker: request/result monitor with list predictor
`timescale 1ns / 1ps

module bounded_ordered_list_engine_core_checker import bole_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bole_in_if   req_mon,
  bole_out_if  res_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] count;
    logic             empty_res;
  } list_result_t;

  // shadow copy of the list, slot 0 is the head
  logic [DATA_WIDTH-1:0] list_mem [CAPACITY];
  int unsigned           list_len;
  list_result_t          expected_q [$];
  int                    errs = 0;

  // open a slot at idx and store word there
  function automatic bit insert_slot(int unsigned idx, logic [DATA_WIDTH-1:0] word);
    if (list_len >= CAPACITY || idx > list_len) return 1'b0;
    for (int i = int'(list_len); i > int'(idx); i--) list_mem[i] = list_mem[i-1];
    list_mem[idx] = word;
    list_len++;
    return 1'b1;
  endfunction

  // close the slot at idx
  function automatic bit drop_slot(int unsigned idx);
    if (idx >= list_len) return 1'b0;
    for (int i = int'(idx); i + 1 < int'(list_len); i++) list_mem[i] = list_mem[i+1];
    list_len--;
    return 1'b1;
  endfunction

  // first slot holding word, -1 when absent (search covers the tail too)
  function automatic int find_word(logic [DATA_WIDTH-1:0] word);
    for (int i = 0; i < int'(list_len); i++)
      if (list_mem[i] == word) return i;
    return -1;
  endfunction

  // apply one request to the shadow list and return the expected result
  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] cmd,
                                                      logic signed [POS_W-1:0] pos,
                                                      logic signed [VAL_W-1:0] val);
    logic [DATA_WIDTH-1:0] word;
    int unsigned           slot;
    int                    found;
    logic                  hit;
    list_result_t          res;
    word = DATA_WIDTH'(val);
    hit  = 1'b0;
    case (cmd)
      CMD_INSERT_FIRST: hit = insert_slot(0, word);
      CMD_INSERT_AT: begin
        if (pos == 0 || list_len == 0) begin
          hit = insert_slot(0, word);
        end else if (pos > 0) begin
          slot = (int'(pos) - 1) % list_len;
          hit  = insert_slot(slot + 1, word);
        end
      end
      CMD_REMOVE_FIRST: hit = drop_slot(0);
      CMD_REMOVE_AT: begin
        if (pos >= 0 && list_len != 0) begin
          if (pos == 0) begin
            hit = drop_slot(0);
          end else begin
            // wrapping past the tail lands on the head
            slot = ((int'(pos) - 1) % list_len + 1) % list_len;
            hit  = drop_slot(slot);
          end
        end
      end
      CMD_ERASE_VALUE: begin
        found = find_word(word);
        if (found >= 0) hit = drop_slot(found);
      end
      CMD_EXISTS: hit = (find_word(word) >= 0);
      CMD_CLEAR: begin
        list_len = 0;
        hit      = 1'b1;
      end
      default: hit = 1'b0;
    endcase
    res.ok        = hit;
    res.count     = CNT_W'(list_len);
    res.empty_res = (list_len == 0);
    return res;
  endfunction

  // compare each result, then predict for each new request
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      list_len = 0;
      expected_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: ok %0d count %0d empty_res %0d",
                 res_mon.ok, res_mon.count, res_mon.empty_res);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (res_mon.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, res_mon.ok);
            errs++;
          end
          if (res_mon.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, res_mon.count);
            errs++;
          end
          if (res_mon.empty_res !== want.empty_res) begin
            $error("empty_res: expected %0d, actual %0d", want.empty_res, res_mon.empty_res);
            errs++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(apply_list_command(req_mon.command, req_mon.position,
                                                req_mon.value));
    end
    fail_count <= errs;
    pending    <= expected_q.size();
  end

endmodule

// File: tb/bounded_ordered_list_engine_core_tb.sv
// bounded_ordered_list_engine_core_tb: stimulus, idling and verdict for the list engine
`timescale 1ns / 1ps

module bounded_ordered_list_engine_core_tb;
  import bole_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd7;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int DRAIN_CYCLES    = 20;

  // list operating mix of a random phase
  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_cnt = 0;
  bit   calm = 1'b0;
  logic signed [VAL_W-1:0] value_pool [8];

  bole_in_if  in_bus ();
  bole_out_if out_bus ();

  bounded_ordered_list_engine_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  bounded_ordered_list_engine_core_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_bus),
    .res_mon    (out_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("bounded_ordered_list_engine_core_tb: errors");
      $finish;
    end
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  initial begin
    int gap;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_bus.ready <= 1'b1;
      repeat (calm ? 50 : $urandom_range(1, 8)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // present one request and hold it until accepted
  task automatic send_request(logic [CMD_W-1:0] cmd, logic signed [POS_W-1:0] pos,
                              logic signed [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.command  <= cmd;
    in_bus.position <= pos;
    in_bus.value    <= val;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // values mostly from a small pool so erase and exists find matches
  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // positions mostly small, some full range and some negative
  function automatic logic signed [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return POS_W'($urandom_range(0, 20));
    if (r < 70) return POS_W'($urandom_range(0, 40));
    if (r < 88) return POS_W'($urandom);
    if (r < 95) return -POS_W'($urandom_range(1, 5));
    return {1'b1, {(POS_W-1){1'b0}}};
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 30) return CMD_INSERT_FIRST;
        if (r < 72) return CMD_INSERT_AT;
        if (r < 82) return CMD_EXISTS;
        if (r < 88) return CMD_REMOVE_AT;
        if (r < 94) return CMD_ERASE_VALUE;
        return CMD_REMOVE_FIRST;
      end
      MIX_DRAIN: begin
        if (r < 25) return CMD_REMOVE_FIRST;
        if (r < 55) return CMD_REMOVE_AT;
        if (r < 75) return CMD_ERASE_VALUE;
        if (r < 85) return CMD_EXISTS;
        if (r < 95) return CMD_INSERT_AT;
        return CMD_INSERT_FIRST;
      end
      default: begin
        if (r < 2) return CMD_CLEAR;
        if (r < 4) return CMD_UNDEFINED;
        if (r < 20) return CMD_INSERT_FIRST;
        if (r < 40) return CMD_INSERT_AT;
        if (r < 52) return CMD_REMOVE_FIRST;
        if (r < 70) return CMD_REMOVE_AT;
        if (r < 85) return CMD_ERASE_VALUE;
        return CMD_EXISTS;
      end
    endcase
  endfunction

  // main sequence
  initial begin
    int   sent;
    int   phase_len;
    mix_t mix;
    in_bus.valid    <= 1'b0;
    in_bus.command  <= CMD_INSERT_FIRST;
    in_bus.position <= '0;
    in_bus.value    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, extremes, wrapping, last entry
    send_request(CMD_REMOVE_FIRST, 16'sd0, 32'sd0);
    send_request(CMD_REMOVE_AT, 16'sd3, 32'sd0);
    send_request(CMD_ERASE_VALUE, 16'sd0, 32'sd5);
    send_request(CMD_EXISTS, 16'sd0, 32'sd5);
    send_request(CMD_CLEAR, 16'sd0, 32'sd0);
    send_request(CMD_INSERT_AT, -16'sd1, 32'sh7FFF_FFFF);
    send_request(CMD_INSERT_FIRST, 16'sd0, 32'sh8000_0000);
    send_request(CMD_INSERT_AT, 16'sd0, 32'sd0);
    send_request(CMD_INSERT_AT, -16'sd1, 32'sd9);
    send_request(CMD_INSERT_AT, 16'sh8000, 32'sd9);
    send_request(CMD_INSERT_AT, 16'sd3, -32'sd1);
    send_request(CMD_INSERT_AT, 16'sh7FFF, 32'sd123);
    send_request(CMD_EXISTS, 16'sd0, -32'sd1);
    send_request(CMD_EXISTS, 16'sd0, 32'sd77);
    send_request(CMD_ERASE_VALUE, 16'sd0, -32'sd1);
    send_request(CMD_REMOVE_AT, -16'sd1, 32'sd0);
    send_request(CMD_REMOVE_AT, 16'sd4, 32'sd0);
    send_request(CMD_REMOVE_AT, 16'sd0, 32'sd0);
    send_request(CMD_REMOVE_AT, 16'sh7FFF, 32'sd0);
    send_request(CMD_UNDEFINED, 16'shFFFF, 32'shFFFF_FFFF);
    send_request(CMD_REMOVE_FIRST, 16'sd0, 32'sd0);
    send_request(CMD_INSERT_FIRST, 16'sd0, 32'sd42);
    send_request(CMD_REMOVE_AT, 16'sd1, 32'sd0);
    send_request(CMD_INSERT_FIRST, 16'sd0, 32'sd42);
    send_request(CMD_CLEAR, 16'sd0, 32'sd0);

    // random phases with varying mix, pool and idling
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      phase_len = $urandom_range(20, 80);
      mix       = mix_t'($urandom_range(0, 2));
      calm      = ($urandom_range(0, 4) == 0);
      value_pool[0] = 32'sh7FFF_FFFF;
      value_pool[1] = 32'sh8000_0000;
      value_pool[2] = 32'sd0;
      value_pool[3] = -32'sd1;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
      repeat (phase_len) begin
        send_request(pick_command(mix), pick_position(), pick_value());
        sent++;
      end
    end
    calm = 1'b0;
    in_bus.valid <= 1'b0;

    // drain outstanding results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("bounded_ordered_list_engine_core_tb: clean");
    else
      $display("bounded_ordered_list_engine_core_tb: errors");
    $finish;
  end

endmodule
